FILE: rtl/core/hlsh_pkg.sv
// Package with the transaction types and fixed widths of the LSH multiprobe key block.
`timescale 1ns / 1ps
`default_nettype none
package hlsh_pkg;

    localparam int unsigned PLANE_W = 3;
    localparam int unsigned INDEX_W = 10;
    localparam int unsigned VALUE_W = 16;
    localparam int unsigned PROD_W  = 2 * VALUE_W;
    localparam int unsigned ACC_W   = 48;
    localparam int unsigned KEY_W   = 8;
    localparam int unsigned NUM_W   = 4;

    localparam int unsigned Q_DEPTH = 4;
    localparam int unsigned Q_PTR_W = 2;
    localparam int unsigned Q_CNT_W = 3;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_FEED = 1'b1;

    typedef struct packed {
        logic                      mode;
        logic [PLANE_W-1:0]        plane_index;
        logic [INDEX_W-1:0]        element_index;
        logic signed [VALUE_W-1:0] value;
        logic                      last_element;
    } t_in_item;

    typedef struct packed {
        logic [KEY_W-1:0] probe_key;
        logic [NUM_W-1:0] probe_number;
        logic             last_probe;
    } t_out_item;

    typedef struct packed {
        logic                      feed;
        logic                      hit;
        logic [PLANE_W-1:0]        plane;
        logic [INDEX_W-1:0]        index;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_cmd;

endpackage
`default_nettype wire

FILE: rtl/core/hyperplane_lsh_multiprobe_keys.sv
// Top level of the random-hyperplane LSH signature and multiprobe key generator.
// Input channel (i_in_valid, o_in_ready, i_in_data): a mode 0 transaction stores one
// plane coefficient, a mode 1 transaction feeds one vector element that is multiplied
// against all planes at once. A feed marked last_element ends the vector.
// Output channel (o_out_valid, i_out_ready, o_out_data): after a last element the block
// sends the primary key and then one key per plane with that bit flipped, the final one
// flagged by last_probe, and clears its accumulators.
// Loads and non-final elements are taken at one per cycle while the four-entry command
// queue has room. A last element passes the coefficient read, the product register and
// the accumulator, then the sequencer registers the primary key and one key per cycle
// follows while the receiver is ready. Commands behind a last element wait until the
// signature is taken; a further last element also waits for the previous keys to issue.
// A stalled receiver holds the output register; a further last element then waits in
// the queue, which fills behind it until o_in_ready falls.
// Reset empties the queue, clears the accumulators and the output; coefficients are
// kept undefined and must be loaded before use.
`timescale 1ns / 1ps
`default_nettype none
module hyperplane_lsh_multiprobe_keys import hlsh_pkg::*; #(
    parameter int unsigned HASHES = 8,
    parameter int unsigned DIM    = 1024
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out_data
);

    logic              head_valid;
    logic              pop;
    t_cmd              head;
    logic              emit_busy;
    logic              start;
    logic [HASHES-1:0] sig;

    hlsh_front #(
        .HASHES(HASHES),
        .DIM   (DIM)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_pop       (pop),
        .o_head_valid(head_valid),
        .o_head      (head)
    );

    hlsh_back #(
        .HASHES(HASHES),
        .DIM   (DIM)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head_valid(head_valid),
        .i_head      (head),
        .o_pop       (pop),
        .i_emit_busy (emit_busy),
        .o_start     (start),
        .o_sig       (sig)
    );

    hlsh_emit #(
        .HASHES(HASHES)
    ) u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_sig      (sig),
        .o_busy     (emit_busy),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

endmodule
`default_nettype wire

FILE: rtl/core/hlsh_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module hlsh_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 1024
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic                                   i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/hlsh_front.sv
// Front end: accepts input transactions, classifies them and queues commands for the back end.
`timescale 1ns / 1ps
`default_nettype none
module hlsh_front import hlsh_pkg::*; #(
    parameter int unsigned HASHES = 8,
    parameter int unsigned DIM    = 1024
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_data,
    input  wire logic     i_pop,
    output logic          o_head_valid,
    output t_cmd          o_head
);

    t_cmd               r_q [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_count, n_count;
    t_cmd               cmd;
    logic               push;
    logic               pop;

    always_comb begin
        cmd.feed  = (i_in_data.mode == MODE_FEED);
        cmd.plane = i_in_data.plane_index;
        cmd.index = i_in_data.element_index;
        cmd.value = i_in_data.value;
        cmd.last  = i_in_data.last_element;
        if (i_in_data.mode == MODE_FEED) begin
            cmd.hit = (32'(i_in_data.element_index) < DIM);
        end else begin
            cmd.hit = (32'(i_in_data.element_index) < DIM) &&
                      (32'(i_in_data.plane_index) < HASHES);
        end
    end

    assign o_in_ready   = (r_count != Q_CNT_W'(Q_DEPTH));
    assign push         = i_in_valid && o_in_ready && (cmd.feed || cmd.hit);
    assign pop          = i_pop && o_head_valid;
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= cmd;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/hlsh_back.sv
// Back end: coefficient memories, per-plane multiply-accumulate lanes and signature capture.
`timescale 1ns / 1ps
`default_nettype none
module hlsh_back import hlsh_pkg::*; #(
    parameter int unsigned HASHES = 8,
    parameter int unsigned DIM    = 1024
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_head_valid,
    input  wire t_cmd        i_head,
    output logic             o_pop,
    input  wire logic        i_emit_busy,
    output logic             o_start,
    output logic [HASHES-1:0] o_sig
);

    localparam int unsigned AW = (DIM > 1) ? $clog2(DIM) : 1;

    logic                      r_s1_valid;
    logic                      r_s1_hit;
    logic                      r_s1_last;
    logic signed [VALUE_W-1:0] r_s1_value;
    logic                      r_s2_valid;
    logic                      r_s2_hit;
    logic                      r_s2_last;
    logic                      r_fin;
    logic                      last_in_flight;
    logic                      feed_pop;
    logic                      acc_zero;
    logic [AW-1:0]             addr;
    logic signed [VALUE_W-1:0] rdata [HASHES];
    logic signed [PROD_W-1:0]  r_prod [HASHES];
    logic [ACC_W-1:0]          r_acc [HASHES];
    logic [HASHES-1:0]         lane_zero;

    assign last_in_flight = (r_s1_valid && r_s1_last) || (r_s2_valid && r_s2_last) || r_fin;
    assign o_pop = i_head_valid && !last_in_flight &&
                   !(i_head.feed && i_head.last && i_emit_busy);
    assign feed_pop = o_pop && i_head.feed;
    assign addr     = AW'(i_head.index);
    assign o_start  = r_fin;
    assign acc_zero = &lane_zero;

    for (genvar h = 0; h < HASHES; h++) begin : g_lane
        hlsh_ram #(
            .WIDTH(VALUE_W),
            .DEPTH(DIM)
        ) u_coeff_ram (
            .i_clk  (i_clk),
            .i_we   (o_pop && !i_head.feed && (32'(i_head.plane) == h)),
            .i_waddr(addr),
            .i_wdata(i_head.value),
            .i_re   (feed_pop),
            .i_raddr(addr),
            .o_rdata(rdata[h])
        );

        always_ff @(posedge i_clk) begin
            if (r_s1_valid) begin
                r_prod[h] <= rdata[h] * r_s1_value;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_acc[h] <= '0;
            end else if (r_fin) begin
                r_acc[h] <= '0;
            end else if (r_s2_valid && r_s2_hit) begin
                r_acc[h] <= r_acc[h] + {{(ACC_W-PROD_W){r_prod[h][PROD_W-1]}}, r_prod[h]};
            end
        end

        assign o_sig[h]     = (r_acc[h] != '0) && !r_acc[h][ACC_W-1];
        assign lane_zero[h] = (r_acc[h] == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_fin      <= 1'b0;
        end else begin
            r_s1_valid <= feed_pop;
            r_s2_valid <= r_s1_valid;
            r_fin      <= r_s2_valid && r_s2_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (feed_pop) begin
            r_s1_hit   <= i_head.hit;
            r_s1_last  <= i_head.last;
            r_s1_value <= i_head.value;
        end
        if (r_s1_valid) begin
            r_s2_hit  <= r_s1_hit;
            r_s2_last <= r_s1_last;
        end
    end

    a_no_pop_during_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        last_in_flight |-> !o_pop)
        else $error("command popped while a last element is still in flight");

    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> !i_emit_busy)
        else $error("signature ready while the key sequencer is still busy");

    a_clear_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |=> acc_zero)
        else $error("accumulators not cleared after the signature was taken");

endmodule
`default_nettype wire

FILE: rtl/core/hlsh_emit.sv
// Key sequencer: sends the primary key and the single-bit-flipped probe keys.
`timescale 1ns / 1ps
`default_nettype none
module hlsh_emit import hlsh_pkg::*; #(
    parameter int unsigned HASHES = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [HASHES-1:0] i_sig,
    output logic                   o_busy,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out_item              o_out_data
);

    localparam int unsigned CW = $clog2(HASHES + 1);

    logic              r_active, n_active;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [HASHES-1:0] r_sig;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out;
    t_out_item         key;
    logic [HASHES-1:0] flip;
    logic              load;

    always_comb begin
        for (int b = 0; b < HASHES; b++) begin
            flip[b] = (32'(r_cnt) == b + 1);
        end
        key.probe_key    = KEY_W'(r_sig ^ flip);
        key.probe_number = NUM_W'(r_cnt);
        key.last_probe   = (32'(r_cnt) == HASHES);
    end

    assign load = r_active && (!r_out_valid || i_out_ready);

    always_comb begin
        n_active    = r_active;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid;
        if (i_start) begin
            n_active = 1'b1;
            n_cnt    = '0;
        end
        if (load) begin
            n_out_valid = 1'b1;
            n_cnt       = r_cnt + 1'b1;
            if (32'(r_cnt) == HASHES) begin
                n_active = 1'b0;
            end
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_sig <= i_sig;
        end
        if (load) begin
            r_out <= key;
        end
    end

    assign o_busy      = r_active;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_active)
        else $error("new signature arrived during a key sequence");

    a_final_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last_probe) |-> (r_out.probe_number == NUM_W'(HASHES)))
        else $error("final probe key carries the wrong probe number");

endmodule
`default_nettype wire
